// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// ===== rtl/mcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfr_pkg
// Shared types and constants of the MIDI channel fan-out router.
// ----------------------------------------------------------------------------
`default_nettype none

package mcfr_pkg;

  // Table limits
  localparam int unsigned MAX_CH       = 16;
  localparam int unsigned DEF_CHANNELS = 16;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // Function codes (tuser on the input side)
  localparam logic [1:0] FUNC_EVENT = 2'd0;
  localparam logic [1:0] FUNC_ROUTE = 2'd1;
  localparam logic [1:0] FUNC_RAW   = 2'd2;

  // Status nibbles and bytes
  localparam logic [3:0] TYPE_PROG     = 4'hC;
  localparam logic [3:0] TYPE_PRESSURE = 4'hD;
  localparam logic [3:0] TYPE_SYSTEM   = 4'hF;
  localparam logic [7:0] SYS_SYSEX     = 8'hF0;
  localparam logic [7:0] SYS_MTC       = 8'hF1;
  localparam logic [7:0] SYS_SONG_POS  = 8'hF2;
  localparam logic [7:0] SYS_SONG_SEL  = 8'hF3;
  localparam logic [7:0] SYS_REALTIME  = 8'hF8;

  // System data follow state
  localparam logic [1:0] FOLLOW_NONE  = 2'd0;
  localparam logic [1:0] FOLLOW_ONE   = 2'd1;
  localparam logic [1:0] FOLLOW_TWO   = 2'd2;
  localparam logic [1:0] FOLLOW_SYSEX = 2'd3;

  // Byte counts
  localparam logic [1:0] CNT_RAW   = 2'd1;
  localparam logic [1:0] CNT_SHORT = 2'd2;
  localparam logic [1:0] CNT_FULL  = 2'd3;

  // Classified work for the emitter: one result per set mask bit,
  // first byte is base ORed with the output channel
  typedef struct packed {
    logic [7:0]        base;
    logic [6:0]        b2;
    logic [6:0]        b3;
    logic [1:0]        cnt;
    logic [MAX_CH-1:0] mask;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/mcfr_front.sv =====
// ----------------------------------------------------------------------------
// mcfr_front
// Accepts input transfers, keeps route table and system follow state, and
// turns each item into at most one job for the emitter queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfr_front import mcfr_pkg::*; #(
  parameter int unsigned CHANNELS = DEF_CHANNELS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  output logic             s_ready_o,
  input  wire logic [55:0] s_data_i,
  input  wire logic [1:0]  s_user_i,
  output logic             push_o,
  output job_t             job_o,
  input  wire logic        q_ready_i
);

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [7:0]  status;
  logic [6:0]  data1;
  logic [6:0]  data2;
  logic [3:0]  route_ch;
  logic [15:0] route_mask;
  logic [7:0]  raw;
  logic        accept;

  logic [CHANNELS-1:0] table_q [CHANNELS];
  logic [1:0]          follow_q, follow_d;

  logic                ev_ch_ok, rt_ch_ok, ev_ok, short_msg, raw_emit;
  logic [CHANNELS-1:0] ev_mask;
  logic [3:0]          ev_type;

  // Field unpacking
  assign status     = s_data_i[7:0];
  assign data1      = s_data_i[14:8];
  assign data2      = s_data_i[21:15];
  assign route_ch   = s_data_i[25:22];
  assign route_mask = s_data_i[41:26];
  assign raw        = s_data_i[49:42];

  assign s_ready_o = q_ready_i;
  assign accept    = s_valid_i & q_ready_i;

  // Channel event classification
  assign ev_type   = status[7:4];
  assign ev_ch_ok  = {1'b0, status[3:0]} < 5'(CHANNELS);
  assign rt_ch_ok  = {1'b0, route_ch} < 5'(CHANNELS);
  assign ev_mask   = table_q[status[CW-1:0]];
  assign short_msg = (ev_type == TYPE_PROG) || (ev_type == TYPE_PRESSURE);
  assign ev_ok     = status[7] && (ev_type != TYPE_SYSTEM) && ev_ch_ok && (ev_mask != '0);

  // Raw byte path: forwarding decision and follow state update
  always_comb begin
    follow_d = follow_q;
    raw_emit = 1'b0;
    if (raw >= SYS_REALTIME) begin
      raw_emit = 1'b1;
    end else if (raw[7:4] == TYPE_SYSTEM) begin
      raw_emit = 1'b1;
      if (raw == SYS_MTC || raw == SYS_SONG_SEL) begin
        follow_d = FOLLOW_ONE;
      end else if (raw == SYS_SONG_POS) begin
        follow_d = FOLLOW_TWO;
      end else if (raw == SYS_SYSEX) begin
        follow_d = FOLLOW_SYSEX;
      end else begin
        follow_d = FOLLOW_NONE;
      end
    end else if (raw[7]) begin
      follow_d = FOLLOW_NONE;
    end else if (follow_q != FOLLOW_NONE) begin
      raw_emit = 1'b1;
      if (follow_q != FOLLOW_SYSEX) begin
        follow_d = follow_q - 2'd1;
      end
    end
  end

  // Job build
  always_comb begin
    push_o = 1'b0;
    job_o  = '0;
    case (s_user_i)
      FUNC_EVENT: begin
        push_o     = accept & ev_ok;
        job_o.base = {ev_type, 4'h0};
        job_o.b2   = data1;
        job_o.b3   = short_msg ? 7'd0 : data2;
        job_o.cnt  = short_msg ? CNT_SHORT : CNT_FULL;
        job_o.mask = MAX_CH'(ev_mask);
      end
      FUNC_RAW: begin
        push_o     = accept & raw_emit;
        job_o.base = raw;
        job_o.cnt  = CNT_RAW;
        job_o.mask = MAX_CH'(1);
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  // Route table writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(CHANNELS); i++) begin
        table_q[i] <= '0;
      end
    end else if (accept && s_user_i == FUNC_ROUTE && rt_ch_ok) begin
      table_q[route_ch[CW-1:0]] <= route_mask[CHANNELS-1:0];
    end
  end

  // System follow state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      follow_q <= FOLLOW_NONE;
    end else if (accept && s_user_i == FUNC_RAW) begin
      follow_q <= follow_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mcfr_queue.sv =====
// ----------------------------------------------------------------------------
// mcfr_queue
// Short job FIFO between classifier and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfr_queue import mcfr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      job_i,
  output logic      ready_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      job_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  job_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign ready_o = cnt_q != NW'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mcfr_back.sv =====
// ----------------------------------------------------------------------------
// mcfr_back
// Emitter: walks a job's channel mask lowest bit first and drives one
// registered result per set bit.
// ----------------------------------------------------------------------------
`default_nettype none

module mcfr_back import mcfr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  job_t             q_job_i,
  output logic             q_pop_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output logic [23:0]      m_data_o,
  output logic             m_last_o
);

  job_t              cur_q;
  logic              cur_valid_q;
  logic              m_valid_q;
  logic [23:0]       m_data_q;
  logic              m_last_q;

  logic [3:0]        low_idx;
  logic [MAX_CH-1:0] low_bit, rem_mask;
  logic              emit;

  // Lowest set bit of the remaining mask
  always_comb begin
    low_idx = '0;
    for (int i = int'(MAX_CH) - 1; i >= 0; i--) begin
      if (cur_q.mask[i]) begin
        low_idx = 4'(i);
      end
    end
  end

  assign low_bit  = cur_q.mask & (~cur_q.mask + 1'b1);
  assign rem_mask = cur_q.mask & ~low_bit;
  assign emit     = cur_valid_q && (!m_valid_q || m_ready_i);
  assign q_pop_o  = !cur_valid_q && q_valid_i;

  // Current job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      cur_valid_q <= 1'b1;
    end else if (emit && rem_mask == '0) begin
      cur_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_job_i;
    end else if (emit) begin
      cur_q.mask <= rem_mask;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= {cur_q.cnt, cur_q.b3, cur_q.b2, cur_q.base | {4'h0, low_idx}};
      m_last_q <= rem_mask == '0;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_last_o  = m_last_q;

endmodule

`default_nettype wire

// ===== rtl/midi_channel_fanout_router.sv =====
// ----------------------------------------------------------------------------
// midi_channel_fanout_router
// Copies MIDI channel events to the output channels set in a per-channel
// route mask and forwards system bytes and their data bytes from raw bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser selects the function (channel event, route mask
//   write, raw byte); tdata carries all operand fields. Output stream: one
//   transfer per result, tlast on the final result of an input item.
//   A route write takes effect for every event accepted after it.
//   The first result of an item passes the job queue, the emitter's job
//   register and the result register. Throughput: the emitter loads an
//   event's job, then drives one result per cycle while the output is not
//   stalled, one per output channel, before it loads the next job.
//   A two-entry job queue sits between classifier and emitter, so input
//   transfers continue while the emitter works, until the queue fills.
//   Reset clears the route table (no routes) and the system follow state.
//   When the output receiver stalls the result register holds, the emitter
//   waits, and input tready drops once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module midi_channel_fanout_router import mcfr_pkg::*; #(
  parameter int unsigned CHANNELS = DEF_CHANNELS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // event_status[7:0], event_data1[14:8], event_data2[21:15],
  // route_channel[25:22], route_mask[41:26], raw_byte[49:42], zero fill
  input  wire logic [55:0] s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // first_byte[7:0], second_byte[14:8], third_byte[21:15], byte_count[23:22]
  output logic [23:0]      m_axis_tdata,
  // last_of_run
  output logic             m_axis_tlast
);

  logic push, q_ready, q_valid, q_pop;
  job_t push_job, head_job;

  // Classifier, table and follow state
  mcfr_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .push_o    (push),
    .job_o     (push_job),
    .q_ready_i (q_ready)
  );

  // Job queue
  mcfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  // Fan-out emitter
  mcfr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_job_i   (head_job),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

  // Checks
  `ASSERT_NEVER(a_cnt_nonzero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[23:22] == 2'd0), "result with zero byte count")
  `ASSERT_PROP(a_raw_last, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[23:22] == CNT_RAW) |-> (m_axis_tlast && m_axis_tdata[21:8] == 14'd0), "raw result not single or not clean")
  `ASSERT_PROP(a_short_b3, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[23:22] == CNT_SHORT) |-> (m_axis_tdata[21:15] == 7'd0), "short event carries third byte")
  `ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, q_pop && !q_valid, "emitter popped empty queue")

endmodule

`default_nettype wire
